@@ src/mpe_pkg.sv @@
// Shared constants, types and helpers for the matrix product engine.
`default_nettype none
package mpe_pkg;

    localparam int MAX_DIM  = 16;
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int CNT_W    = $clog2(MAX_DIM + 1);
    localparam int DIM_W    = 5;
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int ACC_W    = PROD_W + IDX_W;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef enum logic [1:0] {
        REG_LEFT_ROWS  = 2'd0,
        REG_LEFT_COLS  = 2'd1,
        REG_RIGHT_COLS = 2'd2,
        REG_TRANSPOSE  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        FUNC_LOAD_LEFT  = 2'd0,
        FUNC_LOAD_RIGHT = 2'd1,
        FUNC_COMPUTE    = 2'd2,
        FUNC_NONE       = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0] left_rows;
        logic [DIM_W-1:0] left_cols;
        logic [DIM_W-1:0] right_cols;
        logic             transpose_left;
    } cfg_t;

    typedef struct packed {
        logic wr_left;
        logic wr_right;
        logic start;
        logic issue;
        logic emit;
        logic emit_err;
    } cmd_t;

    typedef struct packed {
        logic load_left_ok;
        logic load_right_ok;
        logic res_ok;
        logic last_k;
        logic pipe_busy;
        logic out_free;
    } sts_t;

    // Clamp a dimension register: zero acts as one, above MAX_DIM as MAX_DIM.
    function automatic logic [CNT_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (32'(v) > MAX_DIM)
            r = CNT_W'(MAX_DIM);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/mpe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ src/mpe_ctrl.sv @@
// Controller state machine: accepts transactions and sequences the datapath.
`default_nettype none
module mpe_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [1:0]    func,
    input  wire mpe_pkg::sts_t sts,
    output mpe_pkg::cmd_t      cmd,
    output logic               in_stall
);
    import mpe_pkg::*;

    state_t state_reg, state_next;
    logic   err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && func_t'(func) == FUNC_COMPUTE)
                begin
                    err_next   = !sts.res_ok;
                    state_next = sts.res_ok ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN:
            begin
                if (sts.last_k)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func_t'(func))
                        FUNC_LOAD_LEFT:  cmd.wr_left  = sts.load_left_ok;
                        FUNC_LOAD_RIGHT: cmd.wr_right = sts.load_right_ok;
                        FUNC_COMPUTE:    cmd.start    = sts.res_ok;
                        FUNC_NONE:       cmd.start    = 1'b0;
                    endcase
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.issue = 1'b0;
            end
            ST_FINISH:
            begin
                cmd.emit     = sts.out_free;
                cmd.emit_err = err_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/mpe_dpath.sv @@
// Datapath: matrix stores, multiply-accumulate pipeline and result register.
`default_nettype none
module mpe_dpath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mpe_pkg::cfg_t                cfg,
    input  wire mpe_pkg::cmd_t                cmd,
    output mpe_pkg::sts_t                     sts,
    input  wire logic [mpe_pkg::IDX_W-1:0]    row_index,
    input  wire logic [mpe_pkg::IDX_W-1:0]    col_index,
    input  wire logic [mpe_pkg::DATA_W-1:0]   element_value,
    input  wire logic                         out_stall,
    output logic                              out_valid,
    output logic [mpe_pkg::DATA_W-1:0]        product_value,
    output logic                              saturated,
    output logic                              status
);
    import mpe_pkg::*;

    logic [CNT_W-1:0] lr, lc, rc, inner, res_rows;
    logic [CNT_W-1:0] row_ext, col_ext;

    assign lr       = eff_dim(cfg.left_rows);
    assign lc       = eff_dim(cfg.left_cols);
    assign rc       = eff_dim(cfg.right_cols);
    assign inner    = cfg.transpose_left ? lr : lc;
    assign res_rows = cfg.transpose_left ? lc : lr;
    assign row_ext  = CNT_W'(row_index);
    assign col_ext  = CNT_W'(col_index);

    logic [IDX_W-1:0] row_reg, col_reg;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             s1_vld_reg, s2_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        product_reg;
    logic                     sat_reg, status_reg;

    logic [ADDR_W-1:0] waddr, left_raddr, right_raddr;
    logic [DATA_W-1:0] left_rdata, right_rdata;
    logic [IDX_W-1:0]  k_idx;

    assign k_idx       = k_reg[IDX_W-1:0];
    assign waddr       = {row_index, col_index};
    assign left_raddr  = cfg.transpose_left ? {k_idx, row_reg} : {row_reg, k_idx};
    assign right_raddr = {k_idx, col_reg};

    mpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_left_ram (
        .clk   (clk),
        .we    (cmd.wr_left),
        .waddr (waddr),
        .wdata (element_value),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    mpe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_right_ram (
        .clk   (clk),
        .we    (cmd.wr_right),
        .waddr (waddr),
        .wdata (element_value),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    always_comb
    begin
        k_next = k_reg;
        if (cmd.start)
            k_next = '0;
        else if (cmd.issue)
            k_next = k_reg + CNT_W'(1);
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.start)
            acc_next = '0;
        else if (s2_vld_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    // floor to Q16.16, then saturate
    logic signed [ACC_W-FRAC_W-1:0] shifted;
    logic [ACC_W-FRAC_W-DATA_W:0]   hi_bits;
    logic                           in_range;
    logic [DATA_W-1:0]              sat_value;

    assign shifted   = acc_reg[ACC_W-1:FRAC_W];
    assign hi_bits   = shifted[ACC_W-FRAC_W-1:DATA_W-1];
    assign in_range  = (hi_bits == '0) || (hi_bits == '1);
    assign sat_value = acc_reg[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            s1_vld_reg    <= cmd.issue;
            s2_vld_reg    <= s1_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            row_reg <= row_index;
            col_reg <= col_index;
        end
        if (s1_vld_reg)
        begin
            prod_reg <= $signed(left_rdata) * $signed(right_rdata);
        end
        acc_reg <= acc_next;
        if (cmd.emit)
        begin
            if (cmd.emit_err)
            begin
                product_reg <= '0;
                sat_reg     <= 1'b0;
                status_reg  <= 1'b1;
            end
            else
            begin
                product_reg <= in_range ? shifted[DATA_W-1:0] : sat_value;
                sat_reg     <= !in_range;
                status_reg  <= 1'b0;
            end
        end
    end

    assign sts.load_left_ok  = (row_ext < lr) && (col_ext < lc);
    assign sts.load_right_ok = (row_ext < inner) && (col_ext < rc);
    assign sts.res_ok        = (row_ext < res_rows) && (col_ext < rc);
    assign sts.last_k        = (k_reg == inner - CNT_W'(1));
    assign sts.pipe_busy     = s1_vld_reg || s2_vld_reg;
    assign sts.out_free      = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign product_value = product_reg;
    assign saturated     = sat_reg;
    assign status        = status_reg;

`ifndef NO_ASSERTIONS
    a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("product stage valid without a preceding read");

    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !s1_vld_reg && !s2_vld_reg)
        else $error("compute started with the MAC pipeline busy");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result emitted over an untaken result");

    a_sat_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sat_reg |-> !status_reg)
        else $error("saturation flagged on an error result");
`endif

endmodule
`default_nettype wire

@@ src/matrix_product_engine.sv @@
// Top level: configuration registers, controller and datapath.
//
//  channel  direction  handshake               payload
//  in       to block   in_valid / in_stall     func, row_index, col_index, element_value
//  out      from block out_valid / out_stall   product_value, saturated, status
//  cfg      to block   APB psel/penable/pready paddr, pwdata, prdata
//
// Loads and unused codes are accepted while idle and do not stall the input; a compute is
// set by one shared multiply-accumulate walking the inner dimension, one store read a cycle.
// An out-of-range compute skips the walk and returns an error result with status set.
// Reset clears control and sets the configuration to MAX_DIM dimensions without transpose;
// the stores are not cleared. A finished result waits in the output register while the next transaction is taken.
`default_nettype none
module matrix_product_engine (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     func,
    input  wire logic [mpe_pkg::IDX_W-1:0]      row_index,
    input  wire logic [mpe_pkg::IDX_W-1:0]      col_index,
    input  wire logic signed [mpe_pkg::DATA_W-1:0] element_value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [mpe_pkg::DATA_W-1:0]   product_value,
    output logic                                saturated,
    output logic                                status,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mpe_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [mpe_pkg::PDATA_W-1:0]    pwdata,
    output logic [mpe_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import mpe_pkg::*;

    cfg_t     cfg_reg;
    cmd_t     cmd;
    sts_t     sts;
    reg_idx_t reg_sel;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_rows      <= DIM_RESET;
            cfg_reg.left_cols      <= DIM_RESET;
            cfg_reg.right_cols     <= DIM_RESET;
            cfg_reg.transpose_left <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_LEFT_ROWS:  cfg_reg.left_rows      <= pwdata[DIM_W-1:0];
                REG_LEFT_COLS:  cfg_reg.left_cols      <= pwdata[DIM_W-1:0];
                REG_RIGHT_COLS: cfg_reg.right_cols     <= pwdata[DIM_W-1:0];
                REG_TRANSPOSE:  cfg_reg.transpose_left <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_LEFT_ROWS:  prdata = PDATA_W'(cfg_reg.left_rows);
            REG_LEFT_COLS:  prdata = PDATA_W'(cfg_reg.left_cols);
            REG_RIGHT_COLS: prdata = PDATA_W'(cfg_reg.right_cols);
            REG_TRANSPOSE:  prdata = PDATA_W'(cfg_reg.transpose_left);
        endcase
    end

    mpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    mpe_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .sts           (sts),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .product_value (product_value),
        .saturated     (saturated),
        .status        (status)
    );

endmodule
`default_nettype wire
